### rtl/core/rrts_pkg.sv
package rrts_pkg;

    // Sizing
    localparam int MAX_TASKS = 16;
    localparam int TIME_W    = 32;
    localparam int ID_W      = 4;
    localparam int BURST_W   = 16;
    localparam int QUANT_W   = 8;
    localparam int OUT_W     = 32;
    localparam int CMP_W     = (TIME_W > BURST_W) ? TIME_W : BURST_W;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_QUANTUM = '0;
    localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(4);

    // Request modes
    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // One task record as it travels down the ready queue
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  arrival;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remaining;
        logic               started;
    } t_task;

    // Queue commands from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
    } t_qctl;

    // Queue status back to the sequencer
    typedef struct packed {
        logic head_valid;
        logic full;
        logic hit;
    } t_qstat;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DISP = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    // Clamp a time value to the 32-bit result fields
    function automatic logic [OUT_W-1:0] sat_out(input logic [TIME_W-1:0] v);
        logic [TIME_W+OUT_W-1:0] wide;
        wide = (TIME_W+OUT_W)'(v);
        if ((wide >> OUT_W) != '0) begin
            return '1;
        end
        return wide[OUT_W-1:0];
    endfunction

endpackage

### rtl/core/rrts_cell.sv
module rrts_cell import rrts_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_qctl           i_ctl,
    input  t_task           i_push_rec,
    input  logic            i_left_valid,
    input  logic            i_right_valid,
    input  t_task           i_right_rec,
    input  logic [ID_W-1:0] i_probe_id,
    output logic            o_valid,
    output t_task           o_rec,
    output logic            o_hit
);

    logic  r_valid;
    t_task r_rec;

    // On pop, shift toward the head; the last occupied cell takes a
    // simultaneous push. Otherwise the first empty cell takes the push.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.pop) begin
            if (i_right_valid) begin
                r_valid <= 1'b1;
                r_rec   <= i_right_rec;
            end else if (r_valid && i_ctl.push) begin
                r_valid <= 1'b1;
                r_rec   <= i_push_rec;
            end else begin
                r_valid <= 1'b0;
            end
        end else if (i_ctl.push && !r_valid && i_left_valid) begin
            r_valid <= 1'b1;
            r_rec   <= i_push_rec;
        end
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;
    assign o_hit   = r_valid && (r_rec.id == i_probe_id);

endmodule

### rtl/core/rrts_queue.sv
module rrts_queue import rrts_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_qctl           i_ctl,
    input  t_task           i_push_rec,
    input  logic [ID_W-1:0] i_probe_id,
    output t_task           o_head,
    output t_qstat          o_stat
);

    logic  [MAX_TASKS-1:0] valid;
    logic  [MAX_TASKS-1:0] hit;
    t_task                 rec [MAX_TASKS];

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        logic  left_valid;
        logic  right_valid;
        t_task right_rec;

        if (g == 0) begin : g_first
            assign left_valid = 1'b1;
        end else begin : g_inner
            assign left_valid = valid[g-1];
        end

        if (g == MAX_TASKS-1) begin : g_last
            assign right_valid = 1'b0;
            assign right_rec   = '0;
        end else begin : g_next
            assign right_valid = valid[g+1];
            assign right_rec   = rec[g+1];
        end

        rrts_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (i_ctl),
            .i_push_rec    (i_push_rec),
            .i_left_valid  (left_valid),
            .i_right_valid (right_valid),
            .i_right_rec   (right_rec),
            .i_probe_id    (i_probe_id),
            .o_valid       (valid[g]),
            .o_rec         (rec[g]),
            .o_hit         (hit[g])
        );
    end

    assign o_head            = rec[0];
    assign o_stat.head_valid = valid[0];
    assign o_stat.full       = valid[MAX_TASKS-1];
    assign o_stat.hit        = |hit;

endmodule

### rtl/core/round_robin_time_slice_scheduler.sv
// Preemptive round-robin scheduler. Each request is either an arrival
// (mode 0: enqueue task_id with burst_length, stamped with the current
// time) or a tick (mode 1: run the current task for one time unit,
// dispatching the queue head first when nothing runs or the quantum has
// run out and a task waits; an unfinished current task goes back to the
// tail behind earlier arrivals). Every request yields exactly one result.
// The sequencer steps a tick through queue update and dispatch, then the
// run step with the response and turnaround subtractions, then the
// waiting-time subtraction and the output register; an arrival skips the
// run step. A new request is taken only when the sequencer is idle; a
// result waiting in the output register does not block it, but the next
// result is held until that one is taken. The ready queue is a row of
// MAX_TASKS cells that shift toward the head on every dispatch, each cell
// holding a whole task record (id, arrival, burst, remaining, started), so
// no separate per-task tables exist. time_quantum (APB address 0, reset 4)
// may be written only while no request is in flight.
module round_robin_time_slice_scheduler import rrts_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    // Request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_mode,
    input  logic [ID_W-1:0]     i_task_id,
    input  logic [BURST_W-1:0]  i_burst_length,
    // Result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_accepted,
    output logic [OUT_W-1:0]    o_now_time,
    output logic                o_running_valid,
    output logic [ID_W-1:0]     o_running_id,
    output logic                o_first_start,
    output logic [OUT_W-1:0]    o_response_time,
    output logic                o_preempted,
    output logic                o_completed,
    output logic [OUT_W-1:0]    o_turnaround_time,
    output logic [OUT_W-1:0]    o_waiting_time
);

    t_state               r_state;

    // Latched request
    logic                 r_mode;
    logic [ID_W-1:0]      r_id;
    logic [BURST_W-1:0]   r_burst;

    // Scheduler state
    logic [QUANT_W-1:0]   r_quantum;
    logic [QUANT_W-1:0]   r_qleft;
    logic [TIME_W-1:0]    r_time;
    logic [TIME_W-1:0]    r_fin;
    t_task                r_cur;
    logic                 r_cur_valid;

    // Result being built
    logic                 r_acc;
    logic                 r_run;
    logic                 r_first;
    logic                 r_pre;
    logic                 r_done;
    logic [OUT_W-1:0]     r_now;
    logic [TIME_W-1:0]    r_resp;
    logic [TIME_W-1:0]    r_tat;

    // Output register
    logic                 r_out_valid;
    logic                 r_o_accepted;
    logic [OUT_W-1:0]     r_o_now_time;
    logic                 r_o_running_valid;
    logic [ID_W-1:0]      r_o_running_id;
    logic                 r_o_first_start;
    logic [OUT_W-1:0]     r_o_response_time;
    logic                 r_o_preempted;
    logic                 r_o_completed;
    logic [OUT_W-1:0]     r_o_turnaround_time;
    logic [OUT_W-1:0]     r_o_waiting_time;

    t_qctl                qctl;
    t_qstat               qstat;
    t_task                q_head;
    t_task                disp_rec;
    t_task                push_rec;
    t_task                arrive_rec;
    logic                 in_fire;
    logic                 cfg_write;
    logic                 id_active;
    logic                 arrive_ok;
    logic                 dispatch;
    logic                 requeue;
    logic [BURST_W-1:0]   rem_next;
    logic [CMP_W:0]       wt_diff;
    logic [TIME_W-1:0]    wt;
    logic                 out_free;

    // ---------------------------------------------------------------
    // Configuration: one register, no wait states
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_AW-1:2] == REG_QUANTUM);
    assign prdata    = (paddr[APB_AW-1:2] == REG_QUANTUM)
                       ? APB_DW'(r_quantum) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANT_RESET;
        end else if (cfg_write) begin
            r_quantum <= pwdata[QUANT_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Ready queue
    // ---------------------------------------------------------------
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    // An id is active while queued or running
    assign id_active = qstat.hit || (r_cur_valid && (r_cur.id == r_id));
    assign arrive_ok = (r_burst != '0) && !id_active && !qstat.full
                       && (int'(r_id) < MAX_TASKS);

    // Dispatch when idle or the slice is spent, and someone waits
    assign dispatch = (!r_cur_valid || (r_qleft == '0)) && qstat.head_valid;
    assign requeue  = dispatch && r_cur_valid && (r_cur.remaining != '0);

    always_comb begin
        arrive_rec.id        = r_id;
        arrive_rec.arrival   = r_time;
        arrive_rec.burst     = r_burst;
        arrive_rec.remaining = r_burst;
        arrive_rec.started   = 1'b0;
    end

    // Queue head as it becomes the current task: mark it started
    always_comb begin
        disp_rec         = q_head;
        disp_rec.started = 1'b1;
    end

    assign push_rec = (r_mode == MODE_ARRIVE) ? arrive_rec : r_cur;

    always_comb begin
        qctl = '0;
        if (r_state == ST_DISP) begin
            if (r_mode == MODE_ARRIVE) begin
                qctl.push = arrive_ok;
            end else begin
                qctl.push = requeue;
                qctl.pop  = dispatch;
            end
        end
    end

    rrts_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (qctl),
        .i_push_rec (push_rec),
        .i_probe_id (r_id),
        .o_head     (q_head),
        .o_stat     (qstat)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign rem_next = r_cur.remaining - BURST_W'(r_cur.remaining != '0);
    // Waiting time: turnaround minus burst, clamped at zero
    assign wt_diff  = {1'b0, CMP_W'(r_tat)} - {1'b0, CMP_W'(r_cur.burst)};
    assign wt       = wt_diff[CMP_W] ? '0 : wt_diff[TIME_W-1:0];
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur_valid <= 1'b0;
            r_qleft     <= QUANT_RESET;
            r_time      <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_mode  <= i_mode;
                        r_id    <= i_task_id;
                        r_burst <= i_burst_length;
                        r_now   <= sat_out(r_time);
                        // Saturating successor of the current time
                        r_fin   <= (r_time == '1) ? r_time : r_time + 1'b1;
                        r_acc   <= 1'b0;
                        r_run   <= 1'b0;
                        r_first <= 1'b0;
                        r_pre   <= 1'b0;
                        r_done  <= 1'b0;
                        r_state <= ST_DISP;
                    end
                end
                ST_DISP: begin
                    if (r_mode == MODE_ARRIVE) begin
                        r_acc   <= arrive_ok;
                        r_state <= ST_FIN;
                    end else begin
                        if (dispatch) begin
                            // Take the head with a fresh slice
                            r_cur         <= disp_rec;
                            r_cur_valid   <= 1'b1;
                            r_qleft       <= r_quantum;
                            r_first       <= !q_head.started;
                            r_pre         <= requeue;
                        end
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (r_cur_valid) begin
                        r_run           <= 1'b1;
                        r_cur.remaining <= rem_next;
                        r_resp          <= r_time - r_cur.arrival;
                        r_tat           <= r_fin - r_cur.arrival;
                        if (rem_next == '0) begin
                            // Finished: free the slot, reload the slice
                            r_done      <= 1'b1;
                            r_cur_valid <= 1'b0;
                            r_qleft     <= r_quantum;
                        end else if (r_qleft != '0) begin
                            r_qleft <= r_qleft - 1'b1;
                        end
                    end
                    r_time  <= r_fin;
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    // Hold here until the output register has room
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && out_free) begin
            r_o_accepted        <= r_acc;
            r_o_now_time        <= r_now;
            r_o_running_valid   <= r_run;
            r_o_running_id      <= r_run ? r_cur.id : '0;
            r_o_first_start     <= r_first;
            r_o_response_time   <= r_first ? sat_out(r_resp) : '0;
            r_o_preempted       <= r_pre;
            r_o_completed       <= r_done;
            r_o_turnaround_time <= r_done ? sat_out(r_tat) : '0;
            r_o_waiting_time    <= r_done ? sat_out(wt) : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_accepted        = r_o_accepted;
    assign o_now_time        = r_o_now_time;
    assign o_running_valid   = r_o_running_valid;
    assign o_running_id      = r_o_running_id;
    assign o_first_start     = r_o_first_start;
    assign o_response_time   = r_o_response_time;
    assign o_preempted       = r_o_preempted;
    assign o_completed       = r_o_completed;
    assign o_turnaround_time = r_o_turnaround_time;
    assign o_waiting_time    = r_o_waiting_time;

endmodule

### rtl/core/rrts_checker.sv
module rrts_checker import rrts_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             o_in_ready,
    input  logic             o_out_valid,
    input  logic             i_out_ready,
    input  logic             o_accepted,
    input  logic [OUT_W-1:0] o_now_time,
    input  logic             o_running_valid,
    input  logic             o_first_start,
    input  logic             o_preempted,
    input  logic             o_completed,
    input  logic [OUT_W-1:0] o_turnaround_time,
    input  logic [OUT_W-1:0] o_waiting_time
);

    // A pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_now_time)
            && $stable(o_completed) && $stable(o_turnaround_time))
        else $error("result changed before it was taken");

    // One request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while another is in flight");

    // Tick flags only appear with a running task, never with an arrival
    a_flag_tie: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_first_start || o_completed || o_preempted)
            |-> o_running_valid && !o_accepted)
        else $error("tick flags without a running task");

    // Waiting time never exceeds turnaround
    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_completed |-> o_waiting_time <= o_turnaround_time)
        else $error("waiting time above turnaround");

endmodule

bind round_robin_time_slice_scheduler rrts_checker u_rrts_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_accepted        (o_accepted),
    .o_now_time        (o_now_time),
    .o_running_valid   (o_running_valid),
    .o_first_start     (o_first_start),
    .o_preempted       (o_preempted),
    .o_completed       (o_completed),
    .o_turnaround_time (o_turnaround_time),
    .o_waiting_time    (o_waiting_time)
);

### bench/round_robin_time_slice_scheduler_tb.sv
module round_robin_time_slice_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrts_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 5;
    localparam int IDLE_PCT     = 9;     // chance per cycle that a side holds off
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 8;     // cycles to idle after the last result is taken
    localparam int REPORT_MAX   = 10;
    localparam int PHASE_ITEMS  = 95;

    // One scheduler result, in port order
    typedef struct packed {
        logic             accepted;
        logic [OUT_W-1:0] now_time;
        logic             running_valid;
        logic [ID_W-1:0]  running_id;
        logic             first_start;
        logic [OUT_W-1:0] response_time;
        logic             preempted;
        logic             completed;
        logic [OUT_W-1:0] turnaround_time;
        logic [OUT_W-1:0] waiting_time;
    } sched_result_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic                i_mode = MODE_TICK;
    logic [ID_W-1:0]     i_task_id = '0;
    logic [BURST_W-1:0]  i_burst_length = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_accepted;
    logic [OUT_W-1:0]    o_now_time;
    logic                o_running_valid;
    logic [ID_W-1:0]     o_running_id;
    logic                o_first_start;
    logic [OUT_W-1:0]    o_response_time;
    logic                o_preempted;
    logic                o_completed;
    logic [OUT_W-1:0]    o_turnaround_time;
    logic [OUT_W-1:0]    o_waiting_time;

    round_robin_time_slice_scheduler u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_task_id         (i_task_id),
        .i_burst_length    (i_burst_length),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_accepted        (o_accepted),
        .o_now_time        (o_now_time),
        .o_running_valid   (o_running_valid),
        .o_running_id      (o_running_id),
        .o_first_start     (o_first_start),
        .o_response_time   (o_response_time),
        .o_preempted       (o_preempted),
        .o_completed       (o_completed),
        .o_turnaround_time (o_turnaround_time),
        .o_waiting_time    (o_waiting_time)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scheduler shadow: ready queue, per-task records, current task
    // ------------------------------------------------------------------
    logic [ID_W-1:0]    run_queue [MAX_TASKS];
    int                 run_head = 0;
    int                 run_count = 0;
    bit [TIME_W-1:0]    arrive_stamp [MAX_TASKS];
    bit [BURST_W-1:0]   burst_of [MAX_TASKS];
    bit [BURST_W-1:0]   work_left [MAX_TASKS];
    bit                 has_started [MAX_TASKS];
    bit                 is_active [MAX_TASKS];
    bit                 cur_busy = 1'b0;
    logic [ID_W-1:0]    cur_id = '0;
    logic [QUANT_W-1:0] slice_left = QUANT_RESET;
    logic [TIME_W-1:0]  sched_now = '0;
    logic [QUANT_W-1:0] quantum_cfg = QUANT_RESET;

    sched_result_t      pending_results [$];
    int                 error_count = 0;
    int                 stall_cycles = 0;
    bit                 gaps_on = 1'b1;

    function automatic void flag_error(input string what);
        error_count++;
        if (error_count <= REPORT_MAX) begin
            $display("ERROR @%0t: %s", $realtime, what);
        end
    endfunction

    function automatic string describe_result(input sched_result_t r);
        return $sformatf({"acc=%0b now=%0d run=%0b id=%0d first=%0b resp=%0d ",
                          "pre=%0b done=%0b tat=%0d wt=%0d"},
                         r.accepted, r.now_time, r.running_valid, r.running_id,
                         r.first_start, r.response_time, r.preempted, r.completed,
                         r.turnaround_time, r.waiting_time);
    endfunction

    // Advance the clock count, holding at its maximum
    function automatic logic [TIME_W-1:0] time_after(input logic [TIME_W-1:0] t);
        return (t == '1) ? t : t + 1'b1;
    endfunction

    // Apply one request to the shadow and return the result it must produce
    function automatic sched_result_t predict_schedule(input logic mode,
                                                       input logic [ID_W-1:0] id,
                                                       input logic [BURST_W-1:0] burst);
        sched_result_t r;
        logic [TIME_W-1:0] turn;
        r = '0;
        r.now_time = OUT_W'(sched_now);
        if (mode == MODE_ARRIVE) begin
            // Reject a zero burst, an id already queued or running, or a full queue
            if (burst != '0 && !is_active[id] && run_count < MAX_TASKS) begin
                arrive_stamp[id] = sched_now;
                burst_of[id] = burst;
                work_left[id] = burst;
                has_started[id] = 1'b0;
                is_active[id] = 1'b1;
                run_queue[(run_head + run_count) % MAX_TASKS] = id;
                run_count++;
                r.accepted = 1'b1;
            end
        end else begin
            // Dispatch when idle, or when the slice is spent and someone waits
            if ((!cur_busy || slice_left == '0) && run_count > 0) begin
                if (cur_busy && work_left[cur_id] != '0) begin
                    run_queue[(run_head + run_count) % MAX_TASKS] = cur_id;
                    run_count++;
                    r.preempted = 1'b1;
                end
                cur_id = run_queue[run_head];
                run_head = (run_head + 1) % MAX_TASKS;
                run_count--;
                cur_busy = 1'b1;
                slice_left = quantum_cfg;
                if (!has_started[cur_id]) begin
                    has_started[cur_id] = 1'b1;
                    r.first_start = 1'b1;
                    r.response_time = OUT_W'(sched_now - arrive_stamp[cur_id]);
                end
            end
            if (cur_busy) begin
                r.running_valid = 1'b1;
                r.running_id = cur_id;
                if (work_left[cur_id] != '0) begin
                    work_left[cur_id]--;
                end
                // A spent slice holds at zero until a waiting task takes over
                if (slice_left != '0) begin
                    slice_left--;
                end
                if (work_left[cur_id] == '0) begin
                    turn = time_after(sched_now) - arrive_stamp[cur_id];
                    r.completed = 1'b1;
                    r.turnaround_time = OUT_W'(turn);
                    r.waiting_time = (turn > burst_of[cur_id]) ?
                                     OUT_W'(turn - burst_of[cur_id]) : '0;
                    is_active[cur_id] = 1'b0;
                    cur_busy = 1'b0;
                    slice_left = quantum_cfg;
                end
            end
            sched_now = time_after(sched_now);
        end
        return r;
    endfunction

    // First inactive id at or after start, wrapping; -1 when all are taken
    function automatic int free_task_id(input int start);
        for (int k = 0; k < MAX_TASKS; k++) begin
            if (!is_active[(start + k) % MAX_TASKS]) begin
                return (start + k) % MAX_TASKS;
            end
        end
        return -1;
    endfunction

    // ------------------------------------------------------------------
    // Request driver, result sink, result checker, watchdog
    // ------------------------------------------------------------------

    // Present one request and hold it until accepted. Valid stays high
    // into the next request unless a random gap drops it first.
    task automatic send_request(input logic mode, input logic [ID_W-1:0] id,
                                input logic [BURST_W-1:0] burst);
        if (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (gaps_on && $urandom_range(0, 99) < IDLE_PCT);
        end
        pending_results.push_back(predict_schedule(mode, id, burst));
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_task_id      <= id;
        i_burst_length <= burst;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void check_quantum_read();
        if (prdata !== APB_DW'(quantum_cfg)) begin
            flag_error($sformatf("time_quantum read: exp %0d got %0d", quantum_cfg, prdata));
        end
    endfunction

    // Read back the old quantum, write the new one, read it again.
    // Call only with nothing in flight.
    task automatic set_quantum(input logic [QUANT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'({REG_QUANTUM, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_quantum_read();
        penable <= 1'b0;
        pwrite  <= 1'b1;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        quantum_cfg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_quantum_read();
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result sink: stall at random, except in the steady phase
    always @(posedge i_clk) begin
        i_out_ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compare each taken result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        sched_result_t got;
        sched_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_accepted, o_now_time, o_running_valid, o_running_id, o_first_start,
                   o_response_time, o_preempted, o_completed, o_turnaround_time,
                   o_waiting_time};
            if (pending_results.size() == 0) begin
                flag_error({"result with nothing expected: ", describe_result(got)});
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    flag_error({"result mismatch\n  exp ", describe_result(want),
                                "\n  got ", describe_result(got)});
                end
            end
        end
    end

    // End the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL round_robin_time_slice_scheduler");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle tick, zero-burst rejection, a one-unit task start to finish
    task automatic test_basics();
        set_quantum(QUANT_RESET);
        send_request(MODE_TICK, '0, '0);
        send_request(MODE_ARRIVE, 4'd0, 16'd0);
        send_request(MODE_ARRIVE, 4'd0, 16'd1);
        send_request(MODE_TICK, '1, '1);
        wait_quiet();
    endtask

    // Slice runs out with an empty queue: hold the task, then preempt it
    // on the first tick that finds a newcomer. Duplicate id is rejected.
    task automatic test_quantum_expiry();
        set_quantum(8'd2);
        send_request(MODE_ARRIVE, 4'd15, 16'd5);
        send_request(MODE_ARRIVE, 4'd15, 16'hFFFF);
        repeat (3) send_request(MODE_TICK, 4'hA, 16'h5555);
        send_request(MODE_ARRIVE, 4'd7, 16'd2);
        repeat (5) send_request(MODE_TICK, 4'h5, 16'hAAAA);
        wait_quiet();
    endtask

    // A zero quantum acts as a slice of one
    task automatic test_zero_quantum();
        set_quantum(8'd0);
        send_request(MODE_ARRIVE, 4'd1, 16'd2);
        send_request(MODE_ARRIVE, 4'd2, 16'd1);
        repeat (4) send_request(MODE_TICK, '0, '0);
        wait_quiet();
    endtask

    // Mostly well-formed arrivals of free ids with short bursts, mixed with
    // ticks; the rest are rejected arrivals carrying random payloads.
    task automatic random_request(input int arrive_pct);
        int slot;
        logic [ID_W-1:0] id;
        if ($urandom_range(0, 99) < arrive_pct) begin
            slot = ($urandom_range(0, 99) < 85) ?
                   free_task_id($urandom_range(0, MAX_TASKS - 1)) : -1;
            if (slot >= 0) begin
                send_request(MODE_ARRIVE, ID_W'(slot),
                             ($urandom_range(0, 99) < 80) ? BURST_W'($urandom_range(1, 4))
                                                          : BURST_W'($urandom_range(5, 20)));
            end else begin
                id = ID_W'($urandom);
                send_request(MODE_ARRIVE, id, is_active[id] ? BURST_W'($urandom) : '0);
            end
        end else begin
            send_request(MODE_TICK, ID_W'($urandom), BURST_W'($urandom));
        end
    endtask

    task automatic test_random_traffic(input logic [QUANT_W-1:0] quantum,
                                       input int arrive_pct, input bit steady);
        set_quantum(quantum);
        gaps_on = !steady;
        repeat (PHASE_ITEMS) random_request(arrive_pct);
        wait_quiet();
        gaps_on = 1'b1;
    endtask

    // Largest burst: tick until an id frees up, admit it, run it a little
    task automatic test_long_burst();
        set_quantum(QUANT_RESET);
        while (free_task_id(0) < 0) send_request(MODE_TICK, '0, '0);
        send_request(MODE_ARRIVE, ID_W'(free_task_id($urandom_range(0, MAX_TASKS - 1))),
                     16'hFFFF);
        repeat (6) send_request(MODE_TICK, '1, '0);
        wait_quiet();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basics();
        test_quantum_expiry();
        test_zero_quantum();
        test_random_traffic(8'd1, 20, 1'b0);
        test_random_traffic(8'd255, 20, 1'b1);      // no gaps on either side
        test_random_traffic(8'd3, 55, 1'b0);        // arrivals outpace ticks: fill the queue
        test_random_traffic(QUANT_W'($urandom_range(2, 254)), 20, 1'b0);
        test_long_burst();

        if (error_count == 0) begin
            $display("PASS round_robin_time_slice_scheduler");
        end else begin
            $display("FAIL round_robin_time_slice_scheduler");
        end
        $finish;
    end

endmodule
